// ===== rtl/core/dcvsl_pkg.sv =====
`default_nettype none

package dcvsl_pkg;

   // Field widths
   localparam int unsigned VOLT_W   = 25;
   localparam int unsigned STEP_W   = 20;
   localparam int unsigned THRESH_W = 24;
   localparam int unsigned CSR_W    = 24;

   // Drive range limit in microvolts (+-10 V)
   localparam logic signed [VOLT_W-1:0] VOLT_LIMIT     = 25'sd10000000;
   localparam logic signed [VOLT_W-1:0] VOLT_LIMIT_NEG = -25'sd10000000;

   // Register reset values
   localparam logic [STEP_W-1:0]   BASE_STEP_RESET = 20'd4000;
   localparam logic [THRESH_W-1:0] THRESH_RESET    = 24'd5100000;

   // Register indexes
   localparam logic CSR_BASE_STEP = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   // Request actions; the fourth code is unused and answered with a reject
   typedef enum logic [1:0] {
      ACT_SET  = 2'd0,
      ACT_TICK = 2'd1,
      ACT_STOP = 2'd2
   } action_type;

   // Result kinds
   localparam logic KIND_ACK   = 1'b0;
   localparam logic KIND_DRIVE = 1'b1;

   // One result item
   typedef struct packed {
      logic                     kind;
      logic                     out_channel;
      logic signed [VOLT_W-1:0] drive_voltage;
      logic                     accepted;
      logic                     last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/dual_channel_voltage_slew_limiter_unit.sv =====
// Channel | Ports                                        | Direction | Transfer when
// req     | req_valid/req_stall, action, channel, target | in        | valid & !stall
// rsp     | rsp_valid/rsp_stall, kind .. last            | out       | valid & !stall
// csr     | csr_write_enable, csr_index, csr_write_data  | in        | write_enable
//
// Each request is handled in the cycle it is taken: state updates at that edge and
// its one or two results enter a four-entry result queue.
// A set or stop yields one result, a tick yields two; the queue drains one result per
// cycle while rsp_stall is low, so sets/stops sustain one per cycle; back-to-back ticks raise req_stall.
// req_stall rises while the queue holds more than two results; rsp_stall only holds
// the queue head. Reset (synchronous) clears levels, targets and queue and reloads the registers.
`default_nettype none

module dual_channel_voltage_slew_limiter_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_action,
   input  wire logic [1:0]                             req_channel,
   input  wire logic signed [dcvsl_pkg::VOLT_W-1:0]    req_target_voltage,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_kind,
   output logic                                        rsp_out_channel,
   output logic signed [dcvsl_pkg::VOLT_W-1:0]         rsp_drive_voltage,
   output logic                                        rsp_accepted,
   output logic                                        rsp_last,
   // register write port
   input  wire logic                                   csr_write_enable,
   input  wire logic                                   csr_index,
   input  wire logic [dcvsl_pkg::CSR_W-1:0]            csr_write_data
);

   localparam int unsigned VW   = dcvsl_pkg::VOLT_W;
   localparam int unsigned STW  = dcvsl_pkg::STEP_W + 2;  // step after boost

   // Registers
   logic [dcvsl_pkg::STEP_W-1:0]   base_step_ff;
   logic [dcvsl_pkg::THRESH_W-1:0] threshold_ff;

   // Channel state
   logic signed [VW-1:0] actual_ff [2];
   logic signed [VW-1:0] actual_in [2];
   logic signed [VW-1:0] target_ff [2];
   logic signed [VW-1:0] target_in [2];

   // Result queue
   dcvsl_pkg::rsp_type queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic                 req_xfer;
   logic                 rsp_xfer;
   logic [1:0]           push_count;
   dcvsl_pkg::rsp_type   first_rsp;
   dcvsl_pkg::rsp_type   second_rsp;

   logic [STW-1:0]       step;
   logic signed [VW:0]   act0_wide;
   logic [VW:0]          act0_mag;
   logic                 boost;
   logic                 set_ok;

   assign req_stall = (count_ff > 3'd2);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // Pick the step from channel 0's level before the tick
   always_comb begin
      act0_wide = {actual_ff[0][VW-1], actual_ff[0]};
      act0_mag  = act0_wide[VW] ? $unsigned(-act0_wide) : $unsigned(act0_wide);
      boost     = act0_mag > {{(VW+1-dcvsl_pkg::THRESH_W){1'b0}}, threshold_ff};
      step      = boost ? {base_step_ff, 2'b00} : {2'b00, base_step_ff};
   end

   // Check a set request
   assign set_ok = (req_channel[1] == 1'b0)
                && (req_target_voltage <= dcvsl_pkg::VOLT_LIMIT)
                && (req_target_voltage >= dcvsl_pkg::VOLT_LIMIT_NEG);

   // Decode the request, update levels and build its results
   always_comb begin
      logic signed [VW:0] a_w;
      logic signed [VW:0] diff;
      logic [VW:0]        gap;
      logic signed [VW:0] moved;
      a_w        = '0;
      diff       = '0;
      gap        = '0;
      moved      = '0;
      target_in  = target_ff;
      actual_in  = actual_ff;
      push_count = 2'd1;
      first_rsp  = '{kind: dcvsl_pkg::KIND_ACK, out_channel: 1'b0,
                     drive_voltage: '0, accepted: 1'b0, last: 1'b1};
      second_rsp = first_rsp;
      unique case (dcvsl_pkg::action_type'(req_action))
         dcvsl_pkg::ACT_SET: begin
            first_rsp.accepted = set_ok;
            if (set_ok) begin
               target_in[req_channel[0]] = req_target_voltage;
            end
         end
         dcvsl_pkg::ACT_STOP: begin
            first_rsp.accepted = 1'b1;
            target_in[0]       = '0;
         end
         dcvsl_pkg::ACT_TICK: begin
            push_count = 2'd2;
            for (int k = 0; k < 2; k++) begin
               a_w   = {actual_ff[k][VW-1], actual_ff[k]};
               diff  = a_w - {target_ff[k][VW-1], target_ff[k]};
               gap   = diff[VW] ? $unsigned(-diff) : $unsigned(diff);
               moved = diff[VW] ? a_w + $signed({{(VW+1-STW){1'b0}}, step})
                                : a_w - $signed({{(VW+1-STW){1'b0}}, step});
               if (gap > {{(VW+1-STW){1'b0}}, step}) begin
                  actual_in[k] = moved[VW-1:0];
               end else begin
                  actual_in[k] = target_ff[k];
               end
            end
            first_rsp  = '{kind: dcvsl_pkg::KIND_DRIVE, out_channel: 1'b0,
                           drive_voltage: actual_in[0], accepted: 1'b0, last: 1'b0};
            second_rsp = '{kind: dcvsl_pkg::KIND_DRIVE, out_channel: 1'b1,
                           drive_voltage: actual_in[1], accepted: 1'b0, last: 1'b1};
         end
         default: begin
            first_rsp.accepted = 1'b0;
         end
      endcase
   end

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_xfer) begin
         wr_ptr_in = wr_ptr_ff + push_count;
         count_in  = count_ff + {1'b0, push_count};
      end
      if (rsp_xfer) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         count_in  = count_in - 3'd1;
      end
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff <= dcvsl_pkg::BASE_STEP_RESET;
         threshold_ff <= dcvsl_pkg::THRESH_RESET;
         actual_ff[0] <= '0;
         actual_ff[1] <= '0;
         target_ff[0] <= '0;
         target_ff[1] <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               dcvsl_pkg::CSR_BASE_STEP:
                  base_step_ff <= csr_write_data[dcvsl_pkg::STEP_W-1:0];
               default:
                  threshold_ff <= csr_write_data;
            endcase
         end
         if (req_xfer) begin
            actual_ff <= actual_in;
            target_ff <= target_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write results into the queue
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         queue_ff[wr_ptr_ff] <= first_rsp;
         if (push_count == 2'd2) begin
            queue_ff[wr_ptr_ff + 2'd1] <= second_rsp;
         end
      end
   end

   // Present the queue head
   assign rsp_kind          = queue_ff[rd_ptr_ff].kind;
   assign rsp_out_channel   = queue_ff[rd_ptr_ff].out_channel;
   assign rsp_drive_voltage = queue_ff[rd_ptr_ff].drive_voltage;
   assign rsp_accepted      = queue_ff[rd_ptr_ff].accepted;
   assign rsp_last          = queue_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

// ===== rtl/core/dcvsl_checker.sv =====
`default_nettype none

module dcvsl_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic                                rsp_kind,
   input wire logic                                rsp_out_channel,
   input wire logic signed [dcvsl_pkg::VOLT_W-1:0] rsp_drive_voltage,
   input wire logic                                rsp_accepted,
   input wire logic                                rsp_last
);

   // Queue is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Hold a stalled result
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_channel) && $stable(rsp_drive_voltage)
         && $stable(rsp_accepted) && $stable(rsp_last))
      else $error("stalled result changed");

   // Acknowledge is a single final result with zero payload
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dcvsl_pkg::KIND_ACK) |->
         rsp_last && !rsp_out_channel && (rsp_drive_voltage == '0))
      else $error("malformed acknowledge");

   // Drive results come channel 0 then channel 1, never accepted
   a_drive_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dcvsl_pkg::KIND_DRIVE) |->
         (rsp_last == rsp_out_channel) && !rsp_accepted)
      else $error("malformed drive result");

   // Drive level stays within +-10 V
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dcvsl_pkg::KIND_DRIVE) |->
         (rsp_drive_voltage <= dcvsl_pkg::VOLT_LIMIT)
         && (rsp_drive_voltage >= dcvsl_pkg::VOLT_LIMIT_NEG))
      else $error("drive level out of range");

endmodule

bind dual_channel_voltage_slew_limiter_unit dcvsl_checker u_dcvsl_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Tracks the expected drive results of the slew limiter and checks each one
class slew_scoreboard;
   dcvsl_pkg::rsp_type                         expected_q[$];
   logic signed [dcvsl_pkg::VOLT_W-1:0]        actual_v[2];
   logic signed [dcvsl_pkg::VOLT_W-1:0]        target_v[2];
   logic [dcvsl_pkg::STEP_W-1:0]               step_reg;
   logic [dcvsl_pkg::THRESH_W-1:0]             thresh_reg;
   int                                         mismatches;

   function new();
      actual_v[0] = '0;
      actual_v[1] = '0;
      target_v[0] = '0;
      target_v[1] = '0;
      step_reg    = dcvsl_pkg::BASE_STEP_RESET;
      thresh_reg  = dcvsl_pkg::THRESH_RESET;
      mismatches  = 0;
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction

   function void write_reg(logic index, logic [dcvsl_pkg::CSR_W-1:0] data);
      if (index == dcvsl_pkg::CSR_BASE_STEP)
         step_reg = data[dcvsl_pkg::STEP_W-1:0];
      else
         thresh_reg = data[dcvsl_pkg::THRESH_W-1:0];
   endfunction

   // Update the channel state for one request transfer and queue its results
   function void note_request(logic [1:0] action, logic [1:0] channel,
                              logic signed [dcvsl_pkg::VOLT_W-1:0] target);
      dcvsl_pkg::rsp_type r;
      bit      ok;
      int      step_uv;
      int      lvl;
      int      goal;
      int      gap;
      int      limit;
      r        = '0;
      r.kind   = dcvsl_pkg::KIND_ACK;
      r.last   = 1'b1;
      case (action)
         dcvsl_pkg::ACT_SET: begin
            ok = (channel <= 2'd1) && (target <= dcvsl_pkg::VOLT_LIMIT)
              && (target >= dcvsl_pkg::VOLT_LIMIT_NEG);
            if (ok)
               target_v[channel[0]] = target;
            r.accepted = ok;
            expected_q.push_back(r);
         end
         dcvsl_pkg::ACT_STOP: begin
            target_v[0] = '0;
            r.accepted  = 1'b1;
            expected_q.push_back(r);
         end
         dcvsl_pkg::ACT_TICK: begin
            // boost decision uses channel 0 before this tick moves it
            step_uv = int'(step_reg);
            lvl     = int'(actual_v[0]);
            limit   = int'(thresh_reg);
            if (((lvl < 0) ? -lvl : lvl) > limit)
               step_uv = step_uv * 4;
            for (int k = 0; k < 2; k++) begin
               lvl  = int'(actual_v[k]);
               goal = int'(target_v[k]);
               gap  = lvl - goal;
               if (((gap < 0) ? -gap : gap) > step_uv)
                  lvl = (lvl < goal) ? lvl + step_uv : lvl - step_uv;
               else
                  lvl = goal;
               actual_v[k]     = lvl[dcvsl_pkg::VOLT_W-1:0];
               r.kind          = dcvsl_pkg::KIND_DRIVE;
               r.out_channel   = k[0];
               r.drive_voltage = lvl[dcvsl_pkg::VOLT_W-1:0];
               r.accepted      = 1'b0;
               r.last          = (k == 1);
               expected_q.push_back(r);
            end
         end
         default: begin
            r.accepted = 1'b0;
            expected_q.push_back(r);
         end
      endcase
   endfunction

   function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%s", msg);
   endfunction

   // Compare one result transfer with the oldest expectation
   function void check_result(dcvsl_pkg::rsp_type got);
      dcvsl_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         note_failure($sformatf("unexpected result: kind %0d ch %0d volt %0d acc %0d last %0d",
                      got.kind, got.out_channel, got.drive_voltage, got.accepted, got.last));
         return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.out_channel !== want.out_channel ||
          got.drive_voltage !== want.drive_voltage || got.accepted !== want.accepted ||
          got.last !== want.last)
         note_failure($sformatf({"result mismatch: exp kind %0d ch %0d volt %0d acc %0d ",
                      "last %0d, got kind %0d ch %0d volt %0d acc %0d last %0d"},
                      want.kind, want.out_channel, want.drive_voltage, want.accepted,
                      want.last, got.kind, got.out_channel, got.drive_voltage,
                      got.accepted, got.last));
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned          VW         = dcvsl_pkg::VOLT_W;
   localparam logic [1:0]           ACT_UNUSED = 2'd3;
   localparam logic signed [VW-1:0] TARGET_MAX = 25'h0FFFFFF;
   localparam logic signed [VW-1:0] TARGET_MIN = 25'h1000000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_action = dcvsl_pkg::ACT_SET;
   logic [1:0]                    req_channel = 2'd0;
   logic signed [VW-1:0]          req_target_voltage = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b1;
   logic                          rsp_kind;
   logic                          rsp_out_channel;
   logic signed [VW-1:0]          rsp_drive_voltage;
   logic                          rsp_accepted;
   logic                          rsp_last;
   logic                          csr_write_enable = 1'b0;
   logic                          csr_index = dcvsl_pkg::CSR_BASE_STEP;
   logic [dcvsl_pkg::CSR_W-1:0]   csr_write_data = '0;

   slew_scoreboard sb = new();

   int req_idle_max  = 17;
   int rsp_idle_max  = 17;
   int rsp_long_hold = 0;

   dual_channel_voltage_slew_limiter_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .req_target_voltage (req_target_voltage),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_drive_voltage  (rsp_drive_voltage),
      .rsp_accepted       (rsp_accepted),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #10 clock = ~clock;

   // Check every result transfer
   always @(posedge clock) begin
      dcvsl_pkg::rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind          = rsp_kind;
         got.out_channel   = rsp_out_channel;
         got.drive_voltage = rsp_drive_voltage;
         got.accepted      = rsp_accepted;
         got.last          = rsp_last;
         sb.check_result(got);
      end
   end

   // Result side: stall a random number of cycles before each transfer
   initial begin : result_sink
      int gap;
      wait (!reset);
      @(posedge clock);
      rsp_stall <= 1'b0;
      forever begin
         do @(posedge clock); while (!rsp_valid);
         if (rsp_long_hold > 0) begin
            gap           = rsp_long_hold;
            rsp_long_hold = 0;
         end else begin
            gap = $urandom_range(0, rsp_idle_max);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request and hold it until the transfer
   task automatic send_request(logic [1:0] action, logic [1:0] channel,
                               logic signed [VW-1:0] target);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= action;
      req_channel        <= channel;
      req_target_voltage <= target;
      do @(posedge clock); while (req_stall);
      sb.note_request(action, channel, target);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(logic [dcvsl_pkg::CSR_W-1:0] step_data,
                               logic [dcvsl_pkg::CSR_W-1:0] thresh_data);
      csr_write_enable <= 1'b1;
      csr_index        <= dcvsl_pkg::CSR_BASE_STEP;
      csr_write_data   <= step_data;
      @(posedge clock);
      sb.write_reg(dcvsl_pkg::CSR_BASE_STEP, step_data);
      csr_index      <= dcvsl_pkg::CSR_THRESHOLD;
      csr_write_data <= thresh_data;
      @(posedge clock);
      sb.write_reg(dcvsl_pkg::CSR_THRESHOLD, thresh_data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly ticks and legal sets, with stops, bad sets and unused actions mixed in
   task automatic run_random_items(int count, bit pause_midway);
      int                   pick;
      int                   volts;
      logic signed [VW-1:0] tgt;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2)
            wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_request(dcvsl_pkg::ACT_TICK, 2'($urandom_range(0, 3)), VW'($urandom()));
         end else if (pick < 78) begin
            volts = int'($urandom_range(0, 20000000)) - 10000000;
            if ($urandom_range(0, 9) == 0)
               volts = ($urandom_range(0, 1) != 0) ? 10000000 : -10000000;
            tgt = volts[VW-1:0];
            send_request(dcvsl_pkg::ACT_SET, 2'($urandom_range(0, 1)), tgt);
         end else if (pick < 84) begin
            send_request(dcvsl_pkg::ACT_STOP, 2'($urandom_range(0, 3)), VW'($urandom()));
         end else begin
            send_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         VW'($urandom()));
         end
      end
      wait_idle();
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: ramp by one step, then snap onto the target
      send_request(dcvsl_pkg::ACT_SET, 2'd0, 25'sd5000);
      send_request(dcvsl_pkg::ACT_TICK, 2'd0, '0);
      send_request(dcvsl_pkg::ACT_TICK, 2'd0, '0);
      wait_idle();

      // Large step so that channel 0 crosses the boost threshold
      write_config(24'd1000000, 24'd5100000);
      send_request(dcvsl_pkg::ACT_SET, 2'd0, dcvsl_pkg::VOLT_LIMIT);
      send_request(dcvsl_pkg::ACT_SET, 2'd1, dcvsl_pkg::VOLT_LIMIT_NEG);
      send_request(dcvsl_pkg::ACT_SET, 2'd0, dcvsl_pkg::VOLT_LIMIT + 25'sd1);
      send_request(dcvsl_pkg::ACT_SET, 2'd1, dcvsl_pkg::VOLT_LIMIT_NEG - 25'sd1);
      send_request(dcvsl_pkg::ACT_SET, 2'd2, '0);
      send_request(dcvsl_pkg::ACT_SET, 2'd3, TARGET_MAX);
      send_request(dcvsl_pkg::ACT_SET, 2'd1, TARGET_MIN);
      send_request(ACT_UNUSED, 2'd3, -25'sd1);
      repeat (8) send_request(dcvsl_pkg::ACT_TICK, 2'd0, '0);
      send_request(dcvsl_pkg::ACT_STOP, 2'd1, TARGET_MAX);
      repeat (3) send_request(dcvsl_pkg::ACT_TICK, 2'd0, '0);
      send_request(dcvsl_pkg::ACT_SET, 2'd1, '0);
      send_request(dcvsl_pkg::ACT_TICK, 2'd3, TARGET_MIN);
      wait_idle();

      // Zero step: levels stay where they are
      write_config(24'd0, 24'd0);
      run_random_items(80, 1'b0);

      // Largest step, upper data bits dropped, threshold never reached; no idling
      req_idle_max = 0;
      rsp_idle_max = 0;
      write_config(24'hFFFFFF, 24'hFFFFFF);
      run_random_items(80, 1'b0);
      req_idle_max = 17;
      rsp_idle_max = 17;

      // Smallest step with boost on whenever channel 0 is off zero
      write_config(24'd1, 24'd0);
      run_random_items(80, 1'b0);

      // Receiver holds off long enough to fill the result queue
      write_config(24'($urandom_range(200000, 1000000)), 24'($urandom_range(0, 10000000)));
      rsp_long_hold = 60;
      run_random_items(80, 1'b0);

      // Sender pauses midway until every result has arrived
      write_config(24'($urandom_range(1, 1000000)), 24'($urandom_range(0, 10000000)));
      run_random_items(80, 1'b1);

      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("FAILURE");
      $finish;
   end
endmodule

// ===== dual_channel_voltage_slew_limiter_unit.f =====
rtl/core/dcvsl_pkg.sv
rtl/core/dual_channel_voltage_slew_limiter_unit.sv
rtl/core/dcvsl_checker.sv
sim/tb.sv
